// ===== hw/rtl/tpc_pkg.sv =====
// Package for the triangle plane clipper: payload types, codes and sizes.
package tpc_pkg;

	localparam int CoordW = 32;
	localparam int FracB = 16;
	localparam int DistW = 48;
	localparam int TBits = 31;
	localparam int NumRegs = 6;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_PPX = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PPY = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PPZ = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PNX = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PNY = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PNZ = 3'd5;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DistW-1:0] dist_t;

	typedef struct packed {
		coord_t vert_x;
		coord_t vert_y;
		coord_t vert_z;
		coord_t tex_u;
		coord_t tex_v;
		coord_t tex_w;
	} vert_in_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		coord_t out_u;
		coord_t out_v;
		coord_t out_w;
		logic tri_end;
		logic run_end;
	} vert_out_t;

	typedef coord_t [5:0] vec6_t;

	// One classified triangle between front and back.
	typedef struct packed {
		vec6_t [2:0] v;
		dist_t [2:0] d;
	} tri_t;

endpackage

// ===== hw/rtl/tpc_front.sv =====
// Front part: signed plane distance per vertex and triangle assembly.
module tpc_front import tpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  vert_in_t in_data,
	input  coord_t [5:0] plane,
	output logic tri_valid,
	input  logic tri_ready,
	output tri_t tri_data
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL = 2'd1;
	localparam logic [1:0] F_SUM = 2'd2;
	localparam logic [1:0] F_OUT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] cnt_q;
	logic [1:0] ax_q;
	vec6_t vin_q;
	coord_t [5:0] pl_q;
	logic signed [61:0] acc_q;
	vec6_t [1:0] hv_q;
	dist_t [1:0] hd_q;
	tri_t tri_q;

	logic [2:0] pos_idx, pt_idx, nrm_idx;
	logic signed [CoordW:0] diff;
	logic [CoordW:0] dmag;
	logic [CoordW-1:0] nmag;
	logic [2*CoordW:0] prod;
	logic [2*CoordW-FracB:0] shr;
	logic [60:0] term;
	logic neg;
	logic signed [61:0] acc_next;
	dist_t dsat;

	// One axis product per cycle: magnitude multiply, shift, clamp.
	// The position x sits in the top lane of the vertex vector.
	always_comb begin
		pos_idx = 3'd5 - {1'b0, ax_q};
		pt_idx = {1'b0, ax_q};
		nrm_idx = 3'd3 + {1'b0, ax_q};
		diff = {vin_q[pos_idx][CoordW-1], vin_q[pos_idx]} -
			{pl_q[pt_idx][CoordW-1], pl_q[pt_idx]};
		dmag = diff[CoordW] ? (CoordW+1)'(-diff) : diff;
		nmag = pl_q[nrm_idx][CoordW-1] ? CoordW'(-pl_q[nrm_idx]) : pl_q[nrm_idx];
		prod = (2*CoordW+1)'(dmag * nmag);
		shr = prod[2*CoordW:FracB];
		term = (61'(shr) > 61'h1000000000000000) ?
			61'h1000000000000000 : 61'(shr);
		neg = (diff[CoordW] != pl_q[nrm_idx][CoordW-1]) && (term != '0);
		acc_next = neg ? acc_q - 62'(term) : acc_q + 62'(term);
		if (acc_q > 62'sh7FFFFFFFFFFF) dsat = 48'sh7FFFFFFFFFFF;
		else if (acc_q < -62'sh800000000000) dsat = -48'sh800000000000;
		else dsat = DistW'(acc_q);
	end

	assign full = (state_q != F_IDLE);
	assign tri_valid = (state_q == F_OUT);
	assign tri_data = tri_q;

	// Sequencer: three products, saturate, then hold or hand off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
			ax_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: if (push) begin
					state_q <= F_MUL;
					ax_q <= '0;
				end
				F_MUL: begin
					ax_q <= ax_q + 2'd1;
					if (ax_q == 2'd2) state_q <= F_SUM;
				end
				F_SUM: begin
					if (cnt_q == 2'd2) begin
						state_q <= F_OUT;
						cnt_q <= '0;
					end else begin
						state_q <= F_IDLE;
						cnt_q <= cnt_q + 2'd1;
					end
				end
				F_OUT: if (tri_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			vin_q <= {in_data.vert_x, in_data.vert_y, in_data.vert_z,
				in_data.tex_u, in_data.tex_v, in_data.tex_w};
			pl_q <= plane;
			acc_q <= '0;
		end
		if (state_q == F_MUL) acc_q <= acc_next;
		if (state_q == F_SUM) begin
			if (cnt_q == 2'd2) begin
				tri_q.v <= {vin_q, hv_q[1], hv_q[0]};
				tri_q.d <= {dsat, hd_q[1], hd_q[0]};
			end else begin
				hv_q[cnt_q[0]] <= vin_q;
				hd_q[cnt_q[0]] <= dsat;
			end
		end
	end

	// The vertex count is cleared whenever a triangle is handed off.
	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_OUT |-> cnt_q == 2'd0)
		else $error("front count not cleared on handoff");

endmodule

// ===== hw/rtl/tpc_queue.sv =====
// Two-entry queue of classified triangles between front and back.
module tpc_queue import tpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  tri_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output tri_t rd_data
);

	tri_t [1:0] mem_q;
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// The count never passes the depth, and an empty queue has matching pointers.
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> wp_q == rp_q)
		else $error("queue pointers disagree");

endmodule

// ===== hw/rtl/tpc_back.sv =====
// Back part: picks the output vertex sequence, divides for t and lerps.
module tpc_back import tpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tri_valid,
	output logic tri_ready,
	input  tri_t tri_data,
	output logic empty,
	input  logic pop,
	output vert_out_t res
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_PICK = 3'd1;
	localparam logic [2:0] B_NORM = 3'd2;
	localparam logic [2:0] B_DIV = 3'd3;
	localparam logic [2:0] B_LERP = 3'd4;
	localparam logic [2:0] B_OUT = 3'd5;

	logic [2:0] state_q;
	tri_t t_q;
	logic [2:0] n_q;    // number of outputs
	logic [2:0] k_q;    // current output index
	logic [2:0] lane_q;
	// Per output: source A, source B, crossing flag.
	logic [1:0] sa, sb;
	logic cr;
	logic [DistW-1:0] num_q, den_q;
	logic [TBits:0] t_q2;
	logic [TBits+1:0] rem_q;
	logic [5:0] bit_q;
	vec6_t acc_v_q;
	vert_out_t out_q;

	logic [2:0] ins;
	logic [1:0] ni;
	logic [1:0] i0, i1, o0, o1;

	// Classify: inside flags, first/second inside and outside indexes.
	always_comb begin
		ins = {~t_q.d[2][DistW-1], ~t_q.d[1][DistW-1], ~t_q.d[0][DistW-1]};
		ni = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
		i0 = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
		i1 = (ins[0] && ins[1]) ? 2'd1 : 2'd2;
		o0 = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
		o1 = (!ins[0] && !ins[1]) ? 2'd1 : 2'd2;
		sa = 2'(k_q);
		sb = 2'd0;
		cr = 1'b0;
		if (ni == 2'd1) begin
			sa = i0;
			unique case (k_q)
				3'd0: cr = 1'b0;
				3'd1: begin cr = 1'b1; sb = o0; end
				default: begin cr = 1'b1; sb = o1; end
			endcase
		end else if (ni == 2'd2) begin
			unique case (k_q)
				3'd0: sa = i0;
				3'd1: sa = i1;
				3'd2: begin sa = i0; sb = o0; cr = 1'b1; end
				3'd3: sa = i1;
				3'd4: begin sa = i0; sb = o0; cr = 1'b1; end
				default: begin sa = i1; sb = o0; cr = 1'b1; end
			endcase
		end
	end

	logic [DistW:0] den_full;
	logic [TBits+1:0] trial;
	logic [2:0] lane_idx;
	logic signed [CoordW:0] ldiff;
	logic [CoordW:0] lmag;
	logic [CoordW+TBits:0] lprod;
	logic [CoordW:0] lr;
	coord_t lres;

	// Restoring divide step and one lerp lane per cycle.
	// The dividend is num << 31: 33 bits of num, then 31 zero bits.
	always_comb begin
		den_full = {1'b0, t_q.d[sa]} + {1'b0, -t_q.d[sb]};
		trial = {rem_q[TBits:0], (bit_q >= 6'd31) ? num_q[bit_q - 6'd31] : 1'b0};
		lane_idx = 3'd5 - lane_q;
		ldiff = {t_q.v[sb][lane_idx][CoordW-1], t_q.v[sb][lane_idx]} -
			{t_q.v[sa][lane_idx][CoordW-1], t_q.v[sa][lane_idx]};
		lmag = ldiff[CoordW] ? (CoordW+1)'(-ldiff) : ldiff;
		lprod = (CoordW+TBits+1)'(lmag * t_q2);
		lr = lprod[CoordW+TBits:TBits];
		lres = ldiff[CoordW] ? CoordW'(t_q.v[sa][lane_idx] - CoordW'(lr))
			: CoordW'(t_q.v[sa][lane_idx] + CoordW'(lr));
	end

	assign tri_ready = (state_q == B_IDLE);
	assign empty = (state_q != B_OUT);
	assign res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q <= '0;
			n_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: if (tri_valid) state_q <= B_PICK;
				B_PICK: begin
					k_q <= '0;
					n_q <= (ni == 2'd3) ? 3'd3 : (ni == 2'd2) ? 3'd6 : (ni == 2'd1) ? 3'd3 : 3'd0;
					state_q <= (ni == 2'd0) ? B_IDLE : B_NORM;
				end
				B_NORM: begin
					if (!cr) state_q <= B_OUT;
					else if (den_q[DistW-1:32] == '0) state_q <= B_DIV;
				end
				B_DIV: if (bit_q == 6'd0) state_q <= B_LERP;
				B_LERP: if (lane_q == 3'd5) state_q <= B_OUT;
				B_OUT: if (pop) begin
					k_q <= k_q + 3'd1;
					state_q <= (k_q + 3'd1 == n_q) ? B_IDLE : B_NORM;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Datapath: normalize, divide, lerp, output register.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && tri_valid) t_q <= tri_data;
		if (state_q == B_PICK || (state_q == B_OUT && pop)) begin
			num_q <= '0;
			den_q <= '1;
		end
		if (state_q == B_NORM) begin
			if (!cr) begin
				out_q <= {t_q.v[sa], (k_q == 3'd2 || k_q == 3'd5),
					(k_q + 3'd1 == n_q)};
			end else if (num_q == '0 && den_q == '1) begin
				num_q <= t_q.d[sa];
				den_q <= den_full[DistW-1:0];
			end else if (den_q[DistW-1:32] != '0) begin
				num_q <= num_q >> 1;
				den_q <= den_q >> 1;
			end else begin
				rem_q <= '0;
				t_q2 <= '0;
				bit_q <= 6'd63;
			end
		end
		if (state_q == B_DIV) begin
			if (trial >= (TBits+2)'(den_q[31:0])) begin
				rem_q <= trial - (TBits+2)'(den_q[31:0]);
				t_q2 <= {t_q2[TBits-1:0], 1'b1};
			end else begin
				rem_q <= trial;
				t_q2 <= {t_q2[TBits-1:0], 1'b0};
			end
			bit_q <= bit_q - 6'd1;
			lane_q <= '0;
		end
		if (state_q == B_LERP) begin
			acc_v_q[lane_idx] <= lres;
			lane_q <= lane_q + 3'd1;
			if (lane_q == 3'd5)
				out_q <= {acc_v_q[5:1], lres, (k_q == 3'd2 || k_q == 3'd5),
					(k_q + 3'd1 == n_q)};
		end
	end

	// A presented vertex always lies within the triangle's output count.
	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_OUT |-> k_q < n_q)
		else $error("output index past count");

endmodule

// ===== hw/rtl/triangle_plane_clipper_top.sv =====
// Top level of the triangle plane clipper.
//  channel | handshake        | payload
//  input   | push / full      | in  (vert_in_t)
//  result  | empty / pop      | res (vert_out_t)
//  config  | cfg_we           | cfg_idx, cfg_data
// An input vertex passes through the front as three axis products and a saturate step.
// In the back, a clipped vertex goes through a load, up to 16 normalize
// shifts, a setup step, a 64-step bit-serial divide for t, then six lerp lanes.
// Copied vertices go straight from normalize to the output register in the back.
// Reset clears both sequencers and the queue; stored vertices are undefined.
// The front and back stall independently through a two-triangle queue.
module triangle_plane_clipper_top import tpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  vert_in_t in,
	output logic empty,
	input  logic pop,
	output vert_out_t res,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [CoordW-1:0] cfg_data
);

	coord_t [5:0] plane_q;
	logic fv, fr, bv, br;
	tri_t ft, bt;

	// Configuration registers: point xyz, normal xyz.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= {coord_t'(1 << FracB), {5{coord_t'(0)}}};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PPX: plane_q[0] <= cfg_data;
				REG_PPY: plane_q[1] <= cfg_data;
				REG_PPZ: plane_q[2] <= cfg_data;
				REG_PNX: plane_q[3] <= cfg_data;
				REG_PNY: plane_q[4] <= cfg_data;
				REG_PNZ: plane_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	tpc_front u_front (.clk, .arst_n, .push, .full, .in_data(in), .plane(plane_q),
		.tri_valid(fv), .tri_ready(fr), .tri_data(ft));
	tpc_queue u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(ft),
		.rd_valid(bv), .rd_ready(br), .rd_data(bt));
	tpc_back u_back (.clk, .arst_n, .tri_valid(bv), .tri_ready(br), .tri_data(bt),
		.empty, .pop, .res);

endmodule

// ===== test/tb_triangle_plane_clipper_top.sv =====
// Self-checking testbench for the triangle plane clipper: streamed vertices against a predictor.
module tb_triangle_plane_clipper_top;
	import tpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint six_t [6];

	localparam int DrainCycles = 400;
	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	vert_in_t in = '0;
	logic empty;
	logic pop = 1'b0;
	vert_out_t res;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = REG_PPX;
	logic [CoordW-1:0] cfg_data = '0;

	triangle_plane_clipper_top dut (.*);

	always #5 clk = ~clk;

	// Plane copy used by the predictor, and the open triangle it is building.
	longint plane_pt [3];
	longint plane_nrm [3];
	six_t held_vtx [2];
	longint held_d [2];
	int held_cnt = 0;

	vert_in_t vert_q [$];
	vert_out_t clipped_q [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int cycles = 0;

	// Appends one item to the pending input list.
	task automatic add_vert(vert_in_t v);
		vert_q = {vert_q, v};
	endtask

	function automatic longint unsigned mag(longint a);
		return (a < 0) ? 64'(-a) : 64'(a);
	endfunction

	// One axis product, scaled back by the fraction bits and clamped to 2^60.
	function automatic longint axis_term(longint a, longint b);
		logic [127:0] p;
		logic [127:0] lim;
		longint unsigned r;
		lim = 128'd1 << 60;
		p = (128'(mag(a)) * 128'(mag(b))) >> FracB;
		r = (p > lim) ? 64'd1 << 60 : p[63:0];
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint plane_distance(six_t p);
		longint s;
		longint lim;
		lim = 64'sh7FFF_FFFF_FFFF;
		s = 0;
		for (int i = 0; i < 3; i++)
			s += axis_term(plane_nrm[i], p[i] - plane_pt[i]);
		if (s > lim)
			return lim;
		if (s < -lim - 1)
			return -lim - 1;
		return s;
	endfunction

	// Point where the edge from inside vertex a to outside vertex b meets the plane.
	function automatic six_t edge_cross(six_t a, longint da, six_t b, longint db);
		longint unsigned num, den, t, m, r;
		longint d;
		six_t o;
		num = 64'(da);
		den = 64'(da) + mag(db);
		while (den >= 64'h1_0000_0000) begin
			num >>= 1;
			den >>= 1;
		end
		t = (num << TBits) / den;
		for (int i = 0; i < 6; i++) begin
			d = b[i] - a[i];
			m = mag(d);
			r = (m >> TBits) * t + (((m & 64'h7FFF_FFFF) * t) >> TBits);
			o[i] = (d < 0) ? a[i] - longint'(r) : a[i] + longint'(r);
		end
		return o;
	endfunction

	// Predicts the vertices that one accepted item causes.
	task automatic clip_vertex(vert_in_t v);
		six_t tv [3];
		six_t outv [6];
		longint vdist [3];
		int ins [3];
		int outs [3];
		int ni, no, n;
		vert_out_t e;
		tv[2] = '{longint'(v.vert_x), longint'(v.vert_y), longint'(v.vert_z),
			longint'(v.tex_u), longint'(v.tex_v), longint'(v.tex_w)};
		vdist[2] = plane_distance(tv[2]);
		if (held_cnt < 2) begin
			held_vtx[held_cnt] = tv[2];
			held_d[held_cnt] = vdist[2];
			held_cnt++;
			return;
		end
		held_cnt = 0;
		ni = 0;
		no = 0;
		n = 0;
		for (int k = 0; k < 2; k++) begin
			tv[k] = held_vtx[k];
			vdist[k] = held_d[k];
		end
		for (int k = 0; k < 3; k++) begin
			if (vdist[k] >= 0)
				ins[ni++] = k;
			else
				outs[no++] = k;
		end
		if (ni == 3) begin
			for (int k = 0; k < 3; k++)
				outv[n++] = tv[k];
		end else if (ni == 1) begin
			outv[n++] = tv[ins[0]];
			outv[n++] = edge_cross(tv[ins[0]], vdist[ins[0]], tv[outs[0]], vdist[outs[0]]);
			outv[n++] = edge_cross(tv[ins[0]], vdist[ins[0]], tv[outs[1]], vdist[outs[1]]);
		end else if (ni == 2) begin
			outv[n++] = tv[ins[0]];
			outv[n++] = tv[ins[1]];
			outv[n++] = edge_cross(tv[ins[0]], vdist[ins[0]], tv[outs[0]], vdist[outs[0]]);
			outv[n++] = tv[ins[1]];
			outv[n++] = outv[2];
			outv[n++] = edge_cross(tv[ins[1]], vdist[ins[1]], tv[outs[0]], vdist[outs[0]]);
		end
		for (int k = 0; k < n; k++) begin
			e.out_x = coord_t'(outv[k][0]);
			e.out_y = coord_t'(outv[k][1]);
			e.out_z = coord_t'(outv[k][2]);
			e.out_u = coord_t'(outv[k][3]);
			e.out_v = coord_t'(outv[k][4]);
			e.out_w = coord_t'(outv[k][5]);
			e.tri_end = (k % 3 == 2);
			e.run_end = (k == n - 1);
			clipped_q = {clipped_q, e};
		end
	endtask

	// Sender: predicts on every accepted item, then offers the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				clip_vertex(in);
			if (!push || !full) begin
				if (vert_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					in <= vert_q.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, and each accepted vertex is checked in order.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (clipped_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex %p", res);
				end else if (res !== clipped_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex mismatch: expected %p, got %p", clipped_q[0], res);
					void'(clipped_q.pop_front());
				end else begin
					void'(clipped_q.pop_front());
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL triangle_plane_clipper_top");
			$finish;
		end
	end

	function automatic coord_t near_coord();
		return coord_t'(int'($urandom_range(32'h80000)) - 32'sh40000);
	endfunction

	function automatic vert_in_t make_vert(bit wide);
		vert_in_t v;
		if (wide)
			v = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		else
			v = {near_coord(), near_coord(), near_coord(),
				coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom())};
		return v;
	endfunction

	function automatic vert_in_t at_z(coord_t z, coord_t x);
		return {x, coord_t'(x + 32'sh8000), z, x, z, coord_t'(-x)};
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, coord_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx < REG_PNX)
			plane_pt[idx] = longint'(val);
		else
			plane_nrm[idx - REG_PNX] = longint'(val);
	endtask

	task automatic set_plane(coord_t px, coord_t py, coord_t pz, coord_t nx, coord_t ny,
			coord_t nz);
		write_reg(REG_PPX, px);
		write_reg(REG_PPY, py);
		write_reg(REG_PPZ, pz);
		write_reg(REG_PNX, nx);
		write_reg(REG_PNY, ny);
		write_reg(REG_PNZ, nz);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until the sender is done and every predicted vertex has come out.
	task automatic drain();
		while (vert_q.size() > 0 || push || clipped_q.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic random_items(int count);
		for (int i = 0; i < count; i++)
			add_vert(make_vert($urandom_range(3) == 0));
	endtask

	initial begin
		plane_pt = '{0, 0, 0};
		plane_nrm = '{0, 0, 32'sh10000};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset plane z >= 0: every clip outcome, zero distance and field extremes.
		add_vert(at_z(32'sh10000, 32'sh1000));
		add_vert(at_z(32'sh20000, -32'sh3000));
		add_vert(at_z(0, 32'sh7000));
		add_vert(at_z(-32'sh10000, 32'sh1000));
		add_vert(at_z(-32'sh1, 32'sh2000));
		add_vert(at_z(-32'sh30000, 32'sh3000));
		add_vert(at_z(-32'sh10000, 32'sh10000));
		add_vert(at_z(32'sh10000, -32'sh20000));
		add_vert(at_z(-32'sh30000, 32'sh5000));
		add_vert(at_z(32'sh10000, 32'sh4000));
		add_vert(at_z(-32'sh20000, 32'sh6000));
		add_vert(at_z(32'sh8000, -32'sh9000));
		add_vert({6{32'sh7FFF_FFFF}});
		add_vert({6{32'sh8000_0000}});
		add_vert('0);
		drain();

		// Tilted plane, idle sender; ends with one vertex held.
		set_plane(near_coord(), near_coord(), near_coord(), near_coord(), near_coord(),
			near_coord());
		send_idle_pct = 50;
		random_items(31);
		drain();

		// Plane changes under a held vertex; extreme plane saturates distances.
		set_plane(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		random_items(23);
		drain();

		// Zero normal: every triangle passes through.
		set_plane(near_coord(), near_coord(), near_coord(), 0, 0, 0);
		recv_stall_pct = 29;
		send_idle_pct = 29;
		random_items(9);
		drain();

		// Random plane, both sides idling.
		set_plane(near_coord(), near_coord(), near_coord(), near_coord(), near_coord(),
			near_coord());
		random_items(30);
		drain();

		if (mismatches == 0 && clipped_q.size() == 0)
			$display("PASS triangle_plane_clipper_top");
		else
			$display("FAIL triangle_plane_clipper_top");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_front.sv
hw/rtl/tpc_queue.sv
hw/rtl/tpc_back.sv
hw/rtl/triangle_plane_clipper_top.sv
test/tb_triangle_plane_clipper_top.sv
